### design/pdf_pkg.sv
// package for the periodic decimating fir: word types, codes and constants
`default_nettype none
package pdf_pkg;

    localparam int PDF_MAX_SAMPLES = 128;
    localparam int PDF_MAX_TAPS    = 16;

    localparam int COEF_W      = 36;
    localparam int JOB_N_W     = 8;
    localparam int SMP_ADDR_W  = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int RQ_DEPTH    = 4;

    localparam logic OP_TAP    = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SIZE  = 2'd1;
    localparam logic [1:0] ST_PARAM = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_SHIFT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY_MODE = 2'd2;

    localparam logic [4:0] TAP_COUNT_RESET = 5'd2;
    localparam logic [4:0] MIN_TAPS        = 5'd2;

    localparam logic [3:0] BOUNDARY_FIELD    = 4'hf;
    localparam logic [3:0] BOUNDARY_PERIODIC = 4'h0;

    localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    typedef struct packed {
        logic               opcode;
        logic [3:0]         tap_index;
        logic signed [15:0] value;
        logic               last;
    } in_word_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coefficient;
        logic [5:0]               coef_index;
        logic [1:0]               status;
        logic                     last_result;
    } out_word_t;

    typedef struct packed {
        logic [4:0] tap_count;
        logic [7:0] sample_shift;
        logic [3:0] boundary_mode;
    } cfg_t;

    typedef struct packed {
        logic [JOB_N_W-1:0] n;
        logic [1:0]         status;
    } job_t;

    typedef struct packed {
        logic               en;
        logic [3:0]         idx;
        logic signed [15:0] value;
    } tap_wr_t;

    typedef struct packed {
        logic                  en;
        logic [SMP_ADDR_W-1:0] addr;
        logic signed [15:0]    value;
    } smp_wr_t;

    typedef struct packed {
        logic busy;
        logic job_pop;
    } back_stat_t;

endpackage
`default_nettype wire

### design/pdf_resq.sv
// result queue between the filter back end and the result port
`default_nettype none
module pdf_resq
    import pdf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire out_word_t wdata,
    output logic           full,
    input  wire logic      pop,
    output out_word_t      rdata,
    output logic           empty
);

    localparam int PTR_W = $clog2(RQ_DEPTH);
    localparam int CNT_W = $clog2(RQ_DEPTH + 1);

    out_word_t        mem_reg [RQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(RQ_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = CNT_W'(cnt_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = CNT_W'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule
`default_nettype wire

### design/pdf_front.sv
// front end: input words, config registers, sample count and job queue
`default_nettype none
module pdf_front
    import pdf_pkg::*;
#(
    parameter int MAX_SAMPLES = PDF_MAX_SAMPLES,
    parameter int MAX_TAPS    = PDF_MAX_TAPS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire in_word_t              item,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire back_stat_t            stat,
    output logic                       job_valid,
    output job_t                       job,
    output cfg_t                       cfg,
    output tap_wr_t                    tap_wr,
    output smp_wr_t                    smp_wr
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    cfg_t             cfg_reg, cfg_next;
    job_t             jq_reg [2];
    logic             jq_wr_reg, jq_rd_reg;
    logic [1:0]       jq_cnt_reg, jq_cnt_next;
    logic             accept, room, jq_push;
    logic [CNT_W-1:0] new_count;
    logic             ovf_seen;
    job_t             new_job;

    assign accept    = push && !full;
    assign full      = (jq_cnt_reg != 2'd0) || stat.busy;
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;
    assign job_valid = (jq_cnt_reg != 2'd0);
    assign job       = jq_reg[jq_rd_reg];
    assign room      = (count_reg < CNT_W'(MAX_SAMPLES));
    assign new_count = room ? CNT_W'(count_reg + 1'b1) : count_reg;
    assign ovf_seen  = ovf_reg || !room;

    always_comb
    begin
        tap_wr.en    = accept && (item.opcode == OP_TAP)
                       && (32'(item.tap_index) < MAX_TAPS);
        tap_wr.idx   = item.tap_index;
        tap_wr.value = item.value;
        smp_wr.en    = accept && (item.opcode == OP_SAMPLE) && room;
        smp_wr.addr  = SMP_ADDR_W'(count_reg);
        smp_wr.value = item.value;

        new_job.n = JOB_N_W'(new_count);
        priority if (ovf_seen || new_count[0] || (new_count == '0)
                     || (cfg_reg.tap_count < MIN_TAPS)
                     || (32'(cfg_reg.tap_count) > MAX_TAPS))
        begin
            new_job.status = ST_SIZE;
        end
        else if ((cfg_reg.boundary_mode & BOUNDARY_FIELD) != BOUNDARY_PERIODIC)
        begin
            new_job.status = ST_PARAM;
        end
        else
        begin
            new_job.status = ST_OK;
        end

        count_next = count_reg;
        ovf_next   = ovf_reg;
        jq_push    = 1'b0;
        if (accept && (item.opcode == OP_SAMPLE))
        begin
            if (item.last)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
                jq_push    = 1'b1;
            end
            else
            begin
                count_next = new_count;
                ovf_next   = ovf_seen;
            end
        end

        jq_cnt_next = jq_cnt_reg;
        if (jq_push && !stat.job_pop)
        begin
            jq_cnt_next = jq_cnt_reg + 2'd1;
        end
        else if (stat.job_pop && !jq_push)
        begin
            jq_cnt_next = jq_cnt_reg - 2'd1;
        end

        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_TAP_COUNT:     cfg_next.tap_count     = cfg_data[4:0];
                CFG_SAMPLE_SHIFT:  cfg_next.sample_shift  = cfg_data[7:0];
                CFG_BOUNDARY_MODE: cfg_next.boundary_mode = cfg_data[3:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            jq_wr_reg  <= 1'b0;
            jq_rd_reg  <= 1'b0;
            jq_cnt_reg <= 2'd0;
            cfg_reg    <= '{tap_count: TAP_COUNT_RESET, sample_shift: 8'd0,
                            boundary_mode: 4'd0};
        end
        else
        begin
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            jq_cnt_reg <= jq_cnt_next;
            cfg_reg    <= cfg_next;
            if (jq_push)
            begin
                jq_wr_reg <= !jq_wr_reg;
            end
            if (stat.job_pop)
            begin
                jq_rd_reg <= !jq_rd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (jq_push)
        begin
            jq_reg[jq_wr_reg] <= new_job;
        end
    end

endmodule
`default_nettype wire

### design/pdf_back.sv
// back end: tap store, sample memory and multiply-accumulate sequencer
`default_nettype none
module pdf_back
    import pdf_pkg::*;
#(
    parameter int MAX_SAMPLES = PDF_MAX_SAMPLES,
    parameter int MAX_TAPS    = PDF_MAX_TAPS
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire cfg_t    cfg,
    input  wire tap_wr_t tap_wr,
    input  wire smp_wr_t smp_wr,
    input  wire logic    job_valid,
    input  wire job_t    job,
    output back_stat_t   stat,
    output logic         rq_push,
    output out_word_t    res,
    input  wire logic    rq_full
);

    localparam int ADDR_W = $clog2(MAX_SAMPLES);
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int W1     = CNT_W + 1;
    localparam int TAP_AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int ACC_W  = 32 + TAP_AW;
    localparam int SAT_W  = (ACC_W > COEF_W) ? ACC_W : COEF_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MOD   = 3'd1;
    localparam logic [2:0] S_MAC   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_PUT   = 3'd4;
    localparam logic [2:0] S_ERR   = 3'd5;

    logic signed [15:0]      smp_mem [MAX_SAMPLES];
    logic signed [15:0]      tap_mem_reg [MAX_TAPS];

    logic [2:0]              state_reg, state_next;
    logic [CNT_W-1:0]        n_reg, n_next;
    logic [CNT_W-1:0]        i_reg, i_next;
    logic [4:0]              j_reg, j_next;
    logic [ADDR_W-1:0]       r_reg, r_next;
    logic [ADDR_W-1:0]       base_reg, base_next;
    logic [7:0]              s_reg, s_next;
    logic [1:0]              status_reg, status_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [31:0]      prod_reg;
    logic signed [15:0]      tap_q_reg, smp_q_reg;
    logic                    v1_reg, v2_reg;
    logic                    issue, acc_clr, res_last;

    logic [CNT_W-1:0]        r_plus;
    logic [ADDR_W-1:0]       r_wrap;
    logic [W1-1:0]           b2;
    logic [ADDR_W-1:0]       base_adv;
    logic [ADDR_W-1:0]       start_ptr;
    logic signed [SAT_W-1:0] acc_ext;
    logic signed [COEF_W-1:0] acc_sat;

    // pointer steps with periodic wrap
    assign r_plus    = CNT_W'(r_reg) + CNT_W'(1);
    assign r_wrap    = (r_plus == n_reg) ? '0 : ADDR_W'(r_plus);
    assign b2        = W1'(base_reg) + W1'(2);
    assign base_adv  = (b2 >= W1'(n_reg)) ? ADDR_W'(b2 - W1'(n_reg)) : ADDR_W'(b2);
    assign start_ptr = (s_reg == 8'd0) ? '0 : ADDR_W'(n_reg - CNT_W'(s_reg));
    assign res_last  = (CNT_W'(i_reg + 1'b1) == (n_reg >> 1));

    always_comb
    begin
        acc_ext = SAT_W'(acc_reg);
        priority if (acc_ext > SAT_W'(COEF_MAX))
        begin
            acc_sat = COEF_MAX;
        end
        else if (acc_ext < SAT_W'(COEF_MIN))
        begin
            acc_sat = COEF_MIN;
        end
        else
        begin
            acc_sat = COEF_W'(acc_ext);
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        n_next       = n_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        r_next       = r_reg;
        base_next    = base_reg;
        s_next       = s_reg;
        status_next  = status_reg;
        issue        = 1'b0;
        acc_clr      = 1'b0;
        rq_push      = 1'b0;
        stat.job_pop = 1'b0;
        stat.busy    = (state_reg != S_IDLE);

        res.coefficient = acc_sat;
        res.coef_index  = 6'(i_reg);
        res.status      = ST_OK;
        res.last_result = res_last;

        unique case (state_reg)
            S_IDLE:
            begin
                acc_clr = 1'b1;
                if (job_valid)
                begin
                    stat.job_pop = 1'b1;
                    n_next       = CNT_W'(job.n);
                    status_next  = job.status;
                    s_next       = cfg.sample_shift;
                    i_next       = '0;
                    state_next   = (job.status == ST_OK) ? S_MOD : S_ERR;
                end
            end
            S_ERR:
            begin
                res.coefficient = '0;
                res.coef_index  = '0;
                res.status      = status_reg;
                res.last_result = 1'b1;
                if (!rq_full)
                begin
                    rq_push    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_MOD:
            begin
                // reduce the shift modulo n, one subtraction a cycle
                if (s_reg >= 8'(n_reg))
                begin
                    s_next = s_reg - 8'(n_reg);
                end
                else
                begin
                    base_next  = start_ptr;
                    r_next     = start_ptr;
                    j_next     = '0;
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                issue  = 1'b1;
                j_next = j_reg + 5'd1;
                r_next = r_wrap;
                if ((j_reg + 5'd1) == cfg.tap_count)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                if (!rq_full)
                begin
                    rq_push = 1'b1;
                    acc_clr = 1'b1;
                    if (res_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        i_next     = CNT_W'(i_reg + 1'b1);
                        base_next  = base_adv;
                        r_next     = base_adv;
                        j_next     = '0;
                        state_next = S_MAC;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (acc_clr)
        begin
            acc_next = '0;
        end
        else if (v2_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        r_reg      <= r_next;
        base_reg   <= base_next;
        s_reg      <= s_next;
        status_reg <= status_next;
        acc_reg    <= acc_next;
        prod_reg   <= tap_q_reg * smp_q_reg;
        tap_q_reg  <= tap_mem_reg[TAP_AW'(j_reg)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_TAPS; k++)
            begin
                tap_mem_reg[k] <= '0;
            end
        end
        else if (tap_wr.en)
        begin
            tap_mem_reg[TAP_AW'(tap_wr.idx)] <= tap_wr.value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (smp_wr.en)
        begin
            smp_mem[ADDR_W'(smp_wr.addr)] <= smp_wr.value;
        end
        smp_q_reg <= smp_mem[r_reg];
    end

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        rq_push |-> !rq_full)
        else $error("result pushed into a full queue");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MAC) |-> (CNT_W'(r_reg) < n_reg))
        else $error("sample pointer outside the block");

    a_put_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUT) |-> (!v1_reg && !v2_reg))
        else $error("result taken before the pipeline drained");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (rq_push && res.last_result) |=> (state_reg == S_IDLE))
        else $error("sequencer not idle after the final result");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        stat.job_pop |-> ((state_reg == S_IDLE) && job_valid))
        else $error("job taken while busy or none waiting");

endmodule
`default_nettype wire

### design/periodic_decimating_fir.sv
// top level of the periodic decimating fir
// tap and sample words are taken one per cycle while no block is being filtered
// after the last sample the job is queued and the shift is reduced modulo n, then each result
// runs the multiply-accumulate loop over tap_count taps; a bad job gives one status word instead
// full stays high from the word after the last sample until the final result is queued
// reset clears control state, config to tap_count 2, shift 0, mode 0 and the tap store
// to zero; the sample memory is not cleared
`default_nettype none
module periodic_decimating_fir
    import pdf_pkg::*;
#(
    parameter int MAX_SAMPLES = PDF_MAX_SAMPLES,
    parameter int MAX_TAPS    = PDF_MAX_TAPS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire in_word_t              item,
    output logic                       empty,
    input  wire logic                  pop,
    output out_word_t                  result,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    back_stat_t stat;
    logic       job_valid;
    job_t       job;
    cfg_t       cfg;
    tap_wr_t    tap_wr;
    smp_wr_t    smp_wr;
    logic       rq_push;
    logic       rq_full;
    out_word_t  res;

    pdf_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .MAX_TAPS    (MAX_TAPS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .job_valid (job_valid),
        .job       (job),
        .cfg       (cfg),
        .tap_wr    (tap_wr),
        .smp_wr    (smp_wr)
    );

    pdf_back #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .MAX_TAPS    (MAX_TAPS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .tap_wr    (tap_wr),
        .smp_wr    (smp_wr),
        .job_valid (job_valid),
        .job       (job),
        .stat      (stat),
        .rq_push   (rq_push),
        .res       (res),
        .rq_full   (rq_full)
    );

    pdf_resq u_resq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rq_push),
        .wdata (res),
        .full  (rq_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule
`default_nettype wire

### bench/periodic_decimating_fir_tb.sv
// testbench for the periodic decimating fir: random and directed words checked against a scoreboard
`timescale 1ns / 100ps
module periodic_decimating_fir_tb
    import pdf_pkg::*;
;

    localparam int QUIET_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES = 400;

    class coef_scoreboard;
        logic signed [15:0] taps [PDF_MAX_TAPS];
        logic signed [15:0] samples [PDF_MAX_SAMPLES];
        int unsigned        samples_held;
        bit                 dropped;
        logic [4:0]         tap_count;
        logic [7:0]         sample_shift;
        logic [3:0]         boundary_mode;
        out_word_t          coefs_due [$];
        int unsigned        mismatches;

        function new();
            foreach (taps[k])
                taps[k] = '0;
            foreach (samples[k])
                samples[k] = '0;
            samples_held = 0;
            dropped = 1'b0;
            tap_count = TAP_COUNT_RESET;
            sample_shift = '0;
            boundary_mode = BOUNDARY_PERIODIC;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_TAP_COUNT:     tap_count = data[4:0];
                CFG_SAMPLE_SHIFT:  sample_shift = data;
                CFG_BOUNDARY_MODE: boundary_mode = data[3:0];
                default: ;
            endcase
        endfunction

        function longint filter_at(int i, int n);
            longint acc;
            int     t;
            int     r;
            acc = 0;
            for (int j = 0; j < int'(tap_count); j++)
            begin
                t = 2 * i + j - int'(sample_shift);
                r = t % n;
                if (r < 0)
                    r += n;
                acc += longint'(taps[j]) * longint'(samples[r]);
            end
            if (acc > longint'(COEF_MAX))
                acc = longint'(COEF_MAX);
            if (acc < longint'(COEF_MIN))
                acc = longint'(COEF_MIN);
            return acc;
        endfunction

        function void note_word(in_word_t w);
            int        n;
            logic [1:0] st;
            out_word_t r;
            if (w.opcode == OP_TAP)
            begin
                taps[w.tap_index] = w.value;
                return;
            end
            if (samples_held < PDF_MAX_SAMPLES)
            begin
                samples[samples_held] = w.value;
                samples_held++;
            end
            else
                dropped = 1'b1;
            if (!w.last)
                return;
            n = samples_held;
            st = ST_OK;
            if (dropped || (n % 2) != 0 || n == 0 || tap_count < MIN_TAPS
                || int'(tap_count) > PDF_MAX_TAPS)
                st = ST_SIZE;
            else if ((boundary_mode & BOUNDARY_FIELD) != BOUNDARY_PERIODIC)
                st = ST_PARAM;
            samples_held = 0;
            dropped = 1'b0;
            if (st != ST_OK)
            begin
                r = '0;
                r.status = st;
                r.last_result = 1'b1;
                coefs_due.push_back(r);
                return;
            end
            for (int i = 0; i < n / 2; i++)
            begin
                r.coefficient = COEF_W'(filter_at(i, n));
                r.coef_index = i[5:0];
                r.status = ST_OK;
                r.last_result = (i + 1 == n / 2);
                coefs_due.push_back(r);
            end
        endfunction

        function void check_word(out_word_t got);
            out_word_t want;
            if (coefs_due.size() == 0)
            begin
                $error("unexpected result word: coefficient %0d, index %0d, status %0d",
                       got.coefficient, got.coef_index, got.status);
                mismatches++;
                return;
            end
            want = coefs_due.pop_front();
            if (got.coefficient !== want.coefficient)
            begin
                $error("coefficient: expected %0d, got %0d", want.coefficient, got.coefficient);
                mismatches++;
            end
            if (got.coef_index !== want.coef_index)
            begin
                $error("coef_index: expected %0d, got %0d", want.coef_index, got.coef_index);
                mismatches++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.last_result !== want.last_result)
            begin
                $error("last_result: expected %0d, got %0d", want.last_result, got.last_result);
                mismatches++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    in_word_t              item = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    out_word_t             result;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    coef_scoreboard board = new();
    int  words_sent = 0;
    int  hold_off = 0;
    int  quiet = 0;
    bit  push_calm = 1'b0;
    bit  pop_calm = 1'b0;

    periodic_decimating_fir i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    function automatic logic signed [15:0] rand_value();
        case ($urandom_range(7))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic in_word_t make_word(logic op, logic [3:0] idx, logic signed [15:0] val,
                                           logic last);
        in_word_t w;
        w.opcode = op;
        w.tap_index = idx;
        w.value = val;
        w.last = last;
        return w;
    endfunction

    task automatic send_word(input in_word_t w);
        int gap;
        gap = push_calm ? 0 : $urandom_range(9);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        item <= w;
        do @(posedge clk); while (full);
        board.note_word(w);
        words_sent++;
    endtask

    task automatic send_tap(input logic [3:0] idx, input logic signed [15:0] val);
        send_word(make_word(OP_TAP, idx, val, 1'($urandom())));
    endtask

    task automatic send_block(input int n);
        for (int k = 0; k < n; k++)
            send_word(make_word(OP_SAMPLE, 4'($urandom()), rand_value(), k == n - 1));
    endtask

    // sender goes quiet until every expected word is back
    task automatic drain();
        push <= 1'b0;
        do @(posedge clk); while (board.coefs_due.size() != 0);
    endtask

    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input logic [4:0] taps_used, input logic [7:0] shift,
                              input logic [3:0] mode);
        logic [CFG_IDX_W-1:0]  regs [3];
        logic [CFG_DATA_W-1:0] vals [3];
        regs = '{CFG_TAP_COUNT, CFG_SAMPLE_SHIFT, CFG_BOUNDARY_MODE};
        vals = '{8'(taps_used), shift, 8'(mode)};
        for (int k = 0; k < 3; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[k];
            cfg_data <= vals[k];
            do @(posedge clk); while (!cfg_ready);
            board.set_reg(regs[k], vals[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int budget);
        int stop;
        int r;
        stop = words_sent + budget;
        while (words_sent < stop)
        begin
            r = $urandom_range(99);
            if (r < 20)
                send_tap(4'($urandom()), rand_value());
            else if (r < 80)
                send_block(2 * $urandom_range(1, 8));
            else if (r < 88)
                send_block(2 * $urandom_range(0, 7) + 1);
            else if (r < 94)
                drain();
            else
                send_word(make_word(OP_SAMPLE, 4'($urandom()), rand_value(), 1'($urandom())));
        end
        if (board.samples_held != 0)
            send_word(make_word(OP_SAMPLE, 4'($urandom()), rand_value(), 1'b1));
    endtask

    initial
    begin : drain_results
        int gap;
        @(posedge rst_n);
        forever
        begin
            if (hold_off > 0)
            begin
                pop <= 1'b0;
                repeat (hold_off) @(posedge clk);
                hold_off = 0;
            end
            gap = pop_calm ? 0 : $urandom_range(9);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            board.check_word(result);
        end
    end

    initial
    begin : stimulus
        logic [4:0] taps_used;
        logic [7:0] shift;
        logic [3:0] mode;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: odd block, then a two-sample block with extreme taps
        send_word(make_word(OP_SAMPLE, 4'hf, 16'sh8000, 1'b1));
        send_tap(4'd0, 16'sh7fff);
        send_tap(4'd15, 16'sh8000);
        send_tap(4'd1, 16'sh8000);
        send_word(make_word(OP_SAMPLE, 4'h0, 16'sh7fff, 1'b0));
        send_word(make_word(OP_SAMPLE, 4'h5, 16'sh8000, 1'b1));

        // too few taps, too many taps, bad boundary mode
        settle();
        write_regs(5'd0, 8'd0, 4'd0);
        send_block(2);
        settle();
        write_regs(5'd1, 8'd3, 4'd15);
        send_block(4);
        settle();
        write_regs(5'd16, 8'd255, 4'd15);
        send_block(2);
        settle();
        write_regs(5'd20, 8'd0, 4'd0);
        send_block(2);
        settle();
        write_regs(5'd31, 8'd1, 4'd0);
        send_block(1);

        for (int p = 0; p < 6; p++)
        begin
            settle();
            if (p == 0)
            begin
                taps_used = 5'd16;
                shift = 8'd255;
                mode = 4'd0;
            end
            else if (p == 1)
            begin
                taps_used = MIN_TAPS;
                shift = 8'd0;
                mode = 4'd0;
            end
            else
            begin
                taps_used = 5'($urandom_range(2, 16));
                shift = ($urandom_range(1) == 0) ? 8'($urandom_range(7)) : 8'($urandom());
                mode = ($urandom_range(5) == 0) ? 4'($urandom_range(1, 15)) : 4'd0;
            end
            write_regs(taps_used, shift, mode);
            push_calm = ($urandom_range(3) == 0);
            pop_calm = ($urandom_range(3) == 0);
            random_phase(4);
        end

        // block while the receiver holds off, so results back up and input stalls
        settle();
        write_regs(5'd16, 8'($urandom()), 4'd0);
        push_calm = 1'b1;
        pop_calm = 1'b0;
        hold_off = HOLD_CYCLES;
        send_block(16);
        send_block(6);

        // more samples than the store holds
        settle();
        write_regs(5'($urandom_range(2, 16)), 8'($urandom_range(7)), 4'd0);
        push_calm = 1'b0;
        send_block(PDF_MAX_SAMPLES + 2);

        settle();
        if (board.coefs_due.size() != 0)
        begin
            $error("%0d result words never arrived", board.coefs_due.size());
            board.mismatches++;
        end
        if (board.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
